[design/pff_pkg.sv]
// ----------------------------------------------------------------------------
// pff_pkg
// Shared types and constants of the profile flat finder.
// ----------------------------------------------------------------------------
package pff_pkg;

    // Field widths.
    localparam int LINE_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int NPINS_W   = 4;
    localparam int PIN_NUM_W = 3;

    // Search geometry.
    localparam int RING_DEPTH = 10;
    localparam int MAX_PINS   = 8;
    localparam int DELTA_W    = 10;
    localparam int SUM_W      = DELTA_W + $clog2(RING_DEPTH) + 1;
    localparam int SLOPE_W    = 3;
    localparam int PIN_CNT_W  = (MAX_PINS > 1) ? $clog2(MAX_PINS) : 1;
    localparam int CUR_W      = LINE_W + $clog2(MAX_PINS) + 2;

    localparam int WIDTH_LOW     = 100;
    localparam int WIDTH_HIGH    = 600;
    localparam int SLOPE_DIV     = 5;
    localparam int SLOPE_MAX     = 6;
    localparam int FLAT_MIN      = 20;
    localparam int CENTER_OFFSET = 15;
    localparam int LINE_MAX      = (1 << LINE_W) - 1;

    // Register reset values.
    localparam logic [LINE_W-1:0]  SCAN_START_RST = LINE_W'(1700);
    localparam logic [LINE_W-1:0]  SCAN_END_RST   = LINE_W'(1300);
    localparam logic [LINE_W-1:0]  PIN_PITCH_RST  = '0;
    localparam logic [NPINS_W-1:0] NUM_PINS_RST   = NPINS_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_START = 2'd0,
        CFG_SCAN_END   = 2'd1,
        CFG_PIN_PITCH  = 2'd2,
        CFG_NUM_PINS   = 2'd3
    } t_cfg_reg;

    // One pending result group handed from the search logic to the emitter.
    typedef struct packed {
        logic                       found;
        logic signed [CUR_W-1:0]    first;
        logic [PIN_CNT_W-1:0]       last_idx;
    } t_pin_desc;

endpackage

[design/pff_if.sv]
// ----------------------------------------------------------------------------
// pff_if
// Handshake channels of the profile flat finder: samples, results, config.
// ----------------------------------------------------------------------------
interface pff_in_if;
    logic                       valid;
    logic                       ready;
    logic                       new_scan;
    logic [pff_pkg::LINE_W-1:0] line_index;
    logic [pff_pkg::LINE_W-1:0] edge_width;

    modport source (output valid, output new_scan, output line_index,
                    output edge_width, input ready);
    modport sink   (input valid, input new_scan, input line_index,
                    input edge_width, output ready);
endinterface

interface pff_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [pff_pkg::PIN_NUM_W-1:0] pin_number;
    logic [pff_pkg::LINE_W-1:0]    pin_center;
    logic                          last;

    modport source (output valid, output found, output pin_number,
                    output pin_center, output last, input ready);
    modport sink   (input valid, input found, input pin_number,
                    input pin_center, input last, output ready);
endinterface

interface pff_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pff_pkg::CFG_IDX_W-1:0] index;
    logic [pff_pkg::LINE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/pff_emitter.sv]
// ----------------------------------------------------------------------------
// pff_emitter
// Holds one pending result group and plays it out as result beats through
// an output register, stepping the pin centre down by the pitch each beat.
// ----------------------------------------------------------------------------
module pff_emitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_desc_valid,
    input  pff_pkg::t_pin_desc          i_desc,
    output logic                        o_desc_ready,
    input  logic [pff_pkg::LINE_W-1:0]  i_pin_pitch,
    pff_out_if.source                   o_out
);

    logic                               r_desc_valid;
    pff_pkg::t_pin_desc                 r_desc;
    logic signed [pff_pkg::CUR_W-1:0]   r_cur;
    logic [pff_pkg::PIN_CNT_W-1:0]      r_k;

    logic                               r_out_valid;
    logic                               r_out_found;
    logic [pff_pkg::PIN_NUM_W-1:0]      r_out_pin;
    logic [pff_pkg::LINE_W-1:0]         r_out_center;
    logic                               r_out_last;

    logic                               out_load;
    logic                               beat_last;
    logic                               desc_done;
    logic [pff_pkg::LINE_W-1:0]         center_clamped;

    assign out_load  = r_desc_valid && (!r_out_valid || o_out.ready);
    assign beat_last = !r_desc.found || (r_k == r_desc.last_idx);
    assign desc_done = out_load && beat_last;
    assign o_desc_ready = !r_desc_valid || desc_done;

    always_comb begin
        if (r_cur < 0) begin
            center_clamped = '0;
        end else if (r_cur > pff_pkg::CUR_W'(pff_pkg::LINE_MAX)) begin
            center_clamped = pff_pkg::LINE_W'(pff_pkg::LINE_MAX);
        end else begin
            center_clamped = r_cur[pff_pkg::LINE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_desc_valid) begin
                r_desc_valid <= 1'b1;
            end else if (desc_done) begin
                r_desc_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_desc_valid) begin
            r_desc <= i_desc;
            r_cur  <= i_desc.first;
            r_k    <= '0;
        end else if (out_load) begin
            r_cur <= r_cur - $signed({{(pff_pkg::CUR_W-pff_pkg::LINE_W){1'b0}}, i_pin_pitch});
            r_k   <= r_k + 1'b1;
        end
        if (out_load) begin
            r_out_found  <= r_desc.found;
            r_out_pin    <= r_desc.found ? pff_pkg::PIN_NUM_W'(r_k) : '0;
            r_out_center <= r_desc.found ? center_clamped : '0;
            r_out_last   <= beat_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.found      = r_out_found;
    assign o_out.pin_number = r_out_pin;
    assign o_out.pin_center = r_out_center;
    assign o_out.last       = r_out_last;

    // A not-found beat is always a lone, all-zero final beat.
    a_notfound_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> r_out_last && r_out_center == '0 && r_out_pin == '0)
        else $error("not-found beat malformed");

    // The pin counter never runs past the last pin of the group.
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_desc_valid && r_desc.found |-> r_k <= r_desc.last_idx)
        else $error("pin counter overran group");

    // A stalled result beat stays put until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_found)
            && $stable(r_out_pin) && $stable(r_out_center) && $stable(r_out_last))
        else $error("result beat changed while stalled");

endmodule

[design/profile_flat_finder_core.sv]
// ----------------------------------------------------------------------------
// profile_flat_finder_core
// Finds the first flat of a scanned key profile and reports the pin centres.
// ----------------------------------------------------------------------------
// Samples arrive on i_in, one beat per camera line in descending line order,
// each carrying the line index and the measured edge width. new_scan clears
// the search before its own sample is handled. Results leave on o_out: when
// a flat is found, num_pins beats (clamped to 1..MAX_PINS) of pin centres,
// last set on the final one; if the window ends first, one beat, found low.
// i_cfg writes scan_start, scan_end, pin_pitch and num_pins by index; it is
// always ready and is meant to be used only while the block is idle.
// A sample updates the search state at its accepting edge, and its result
// group is captured in the emitter at that same edge. Its beats then pass
// from the emitter's group register into the output register and follow one
// per cycle while o_out is ready. Throughput is one sample per cycle while
// the emitter holds no pending group. With o_out ready, a sample that
// produces several result beats holds i_in low until the emitter has moved
// the last of them into the single output register, one beat at a time.
// When o_out stalls, one result group waits in the emitter and i_in drops
// ready until the last beat of that group has moved into the output
// register. Reset (synchronous, active low) loads the register defaults and
// clears all search state; no sweep is needed.
// ----------------------------------------------------------------------------
module profile_flat_finder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pff_in_if.sink      i_in,
    pff_out_if.source   o_out,
    pff_cfg_if.sink     i_cfg
);

    // Configuration registers.
    logic [pff_pkg::LINE_W-1:0]     r_scan_start;
    logic [pff_pkg::LINE_W-1:0]     r_scan_end;
    logic [pff_pkg::LINE_W-1:0]     r_pin_pitch;
    logic [pff_pkg::NPINS_W-1:0]    r_num_pins;

    // Search state.
    logic signed [pff_pkg::DELTA_W-1:0] r_ring [pff_pkg::RING_DEPTH];
    logic signed [pff_pkg::SUM_W-1:0]   r_sum;
    logic [pff_pkg::DELTA_W-1:0]        r_prev;
    logic                               r_valid_seen;
    logic [pff_pkg::SLOPE_W-1:0]        r_slope;
    logic                               r_in_slope;
    logic [pff_pkg::LINE_W-1:0]         r_fb;
    logic                               r_done;

    logic signed [pff_pkg::SUM_W-1:0]   n_sum;
    logic [pff_pkg::DELTA_W-1:0]        n_prev;
    logic                               n_valid_seen;
    logic [pff_pkg::SLOPE_W-1:0]        n_slope;
    logic                               n_in_slope;
    logic [pff_pkg::LINE_W-1:0]         n_fb;
    logic                               n_done;
    logic                               n_shift;

    logic                               accept;
    logic                               clr;
    logic [pff_pkg::LINE_W-1:0]         line;
    logic [pff_pkg::LINE_W-1:0]         width;
    logic [pff_pkg::LINE_W-1:0]         j;
    logic                               width_ok;

    logic signed [pff_pkg::SUM_W-1:0]   e_sum;
    logic signed [pff_pkg::DELTA_W-1:0] e_oldest;
    logic [pff_pkg::DELTA_W-1:0]        e_prev;
    logic                               e_valid_seen;
    logic [pff_pkg::SLOPE_W-1:0]        e_slope;
    logic                               e_in_slope;
    logic [pff_pkg::LINE_W-1:0]         e_fb;
    logic                               e_done;

    logic signed [pff_pkg::DELTA_W:0]   delta_full;
    logic signed [pff_pkg::DELTA_W-1:0] delta;
    logic signed [pff_pkg::SUM_W-1:0]   sum_new;
    logic                               slope_hit;
    logic signed [pff_pkg::LINE_W:0]    flat_len;
    logic signed [pff_pkg::CUR_W-1:0]   first;
    logic [pff_pkg::PIN_CNT_W-1:0]      last_idx;

    logic                               desc_valid;
    pff_pkg::t_pin_desc                 desc;
    logic                               desc_ready;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_start <= pff_pkg::SCAN_START_RST;
            r_scan_end   <= pff_pkg::SCAN_END_RST;
            r_pin_pitch  <= pff_pkg::PIN_PITCH_RST;
            r_num_pins   <= pff_pkg::NUM_PINS_RST;
        end else if (i_cfg.valid) begin
            unique case (pff_pkg::t_cfg_reg'(i_cfg.index))
                pff_pkg::CFG_SCAN_START: r_scan_start <= i_cfg.data;
                pff_pkg::CFG_SCAN_END:   r_scan_end   <= i_cfg.data;
                pff_pkg::CFG_PIN_PITCH:  r_pin_pitch  <= i_cfg.data;
                pff_pkg::CFG_NUM_PINS:   r_num_pins   <= i_cfg.data[pff_pkg::NPINS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- search step ----------------
    assign accept = i_in.valid && i_in.ready;
    assign clr    = i_in.new_scan;
    assign line   = i_in.line_index;
    assign width  = i_in.edge_width;
    assign j      = line - 1'b1;
    assign width_ok = (width > pff_pkg::LINE_W'(pff_pkg::WIDTH_LOW))
                   && (width < pff_pkg::LINE_W'(pff_pkg::WIDTH_HIGH));

    // State as seen after an optional clear by new_scan.
    assign e_sum        = clr ? '0 : r_sum;
    assign e_oldest     = clr ? '0 : r_ring[pff_pkg::RING_DEPTH-1];
    assign e_prev       = clr ? '0 : r_prev;
    assign e_valid_seen = clr ? 1'b0 : r_valid_seen;
    assign e_slope      = clr ? '0 : r_slope;
    assign e_in_slope   = clr ? 1'b0 : r_in_slope;
    assign e_fb         = clr ? '0 : r_fb;
    assign e_done       = clr ? 1'b0 : r_done;

    assign delta_full = $signed({1'b0, e_prev}) - $signed({1'b0, width[pff_pkg::DELTA_W-1:0]});
    assign delta      = delta_full[pff_pkg::DELTA_W-1:0];
    assign sum_new    = e_sum - pff_pkg::SUM_W'(e_oldest) + pff_pkg::SUM_W'(delta);
    assign slope_hit  = (sum_new >= pff_pkg::SUM_W'(pff_pkg::SLOPE_DIV))
                     || (sum_new <= -pff_pkg::SUM_W'(pff_pkg::SLOPE_DIV));

    // Flat length and first centre; the centre only matters when the length
    // is at least the minimum, so the halving is a plain shift.
    assign flat_len = $signed({1'b0, e_fb}) - $signed({1'b0, j});
    assign first    = pff_pkg::CUR_W'(e_fb) - pff_pkg::CUR_W'(flat_len[pff_pkg::LINE_W:1])
                    + pff_pkg::CUR_W'(pff_pkg::CENTER_OFFSET);

    always_comb begin
        if (r_num_pins == '0) begin
            last_idx = '0;
        end else if (5'(r_num_pins) > 5'(pff_pkg::MAX_PINS)) begin
            last_idx = pff_pkg::PIN_CNT_W'(pff_pkg::MAX_PINS - 1);
        end else begin
            last_idx = pff_pkg::PIN_CNT_W'(r_num_pins - 1'b1);
        end
    end

    always_comb begin
        n_sum        = e_sum;
        n_prev       = e_prev;
        n_valid_seen = e_valid_seen;
        n_slope      = e_slope;
        n_in_slope   = e_in_slope;
        n_fb         = e_fb;
        n_done       = e_done;
        n_shift      = 1'b0;
        desc_valid   = 1'b0;
        desc.found    = 1'b0;
        desc.first    = '0;
        desc.last_idx = '0;

        if (e_done) begin
            // Search over: samples wait for the next new_scan.
        end else if (line <= r_scan_end) begin
            n_done     = 1'b1;
            desc_valid = 1'b1;
        end else if (line <= r_scan_start) begin
            if (width_ok && !e_valid_seen) begin
                n_prev       = width[pff_pkg::DELTA_W-1:0];
                n_valid_seen = 1'b1;
            end else if (width_ok && j > r_scan_end) begin
                n_prev  = width[pff_pkg::DELTA_W-1:0];
                n_sum   = sum_new;
                n_shift = 1'b1;
                if (slope_hit) begin
                    if (e_slope < pff_pkg::SLOPE_W'(pff_pkg::SLOPE_MAX)) begin
                        n_slope = e_slope + 1'b1;
                    end else begin
                        n_in_slope = 1'b1;
                        if (e_fb != '0) begin
                            if (flat_len < (pff_pkg::LINE_W+1)'(pff_pkg::FLAT_MIN)) begin
                                n_fb = '0;
                            end else begin
                                n_done        = 1'b1;
                                desc_valid    = 1'b1;
                                desc.found    = 1'b1;
                                desc.first    = first;
                                desc.last_idx = last_idx;
                            end
                        end
                    end
                end else if (e_slope != '0) begin
                    n_slope = e_slope - 1'b1;
                    if (e_in_slope && e_slope == pff_pkg::SLOPE_W'(1) && e_fb == '0) begin
                        n_fb = j;
                    end
                end
            end
            // The window closes on the sample just above scan_end.
            if (!desc_valid && j <= r_scan_end) begin
                n_done     = 1'b1;
                desc_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_prev       <= '0;
            r_valid_seen <= 1'b0;
            r_slope      <= '0;
            r_in_slope   <= 1'b0;
            r_fb         <= '0;
            r_done       <= 1'b0;
            for (int i = 0; i < pff_pkg::RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else if (accept) begin
            r_sum        <= n_sum;
            r_prev       <= n_prev;
            r_valid_seen <= n_valid_seen;
            r_slope      <= n_slope;
            r_in_slope   <= n_in_slope;
            r_fb         <= n_fb;
            r_done       <= n_done;
            // The ring is a shift line: the oldest difference sits at the end.
            for (int i = 0; i < pff_pkg::RING_DEPTH; i++) begin
                if (n_shift) begin
                    r_ring[i] <= (i == 0) ? delta : r_ring[(i == 0) ? 0 : i - 1];
                end else if (clr) begin
                    r_ring[i] <= '0;
                end
            end
            if (n_shift && clr) begin
                for (int i = 1; i < pff_pkg::RING_DEPTH; i++) begin
                    r_ring[i] <= '0;
                end
            end
        end
    end

    // ---------------- result emitter ----------------
    assign i_in.ready = desc_ready;

    pff_emitter u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (accept && desc_valid),
        .i_desc       (desc),
        .o_desc_ready (desc_ready),
        .i_pin_pitch  (r_pin_pitch),
        .o_out        (o_out)
    );

    a_slope_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slope <= pff_pkg::SLOPE_W'(pff_pkg::SLOPE_MAX))
        else $error("slope counter out of range");

    // A flat can only be open once a slope has been seen.
    a_flat_after_slope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fb != '0 |-> r_in_slope)
        else $error("flat open without a preceding slope");

    // No difference enters the moving sum before the first used width.
    a_sum_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid_seen |-> r_sum == '0)
        else $error("moving sum changed before the first used sample");

endmodule
